### design/qtn_pkg.sv
// Shared constants and types of the query text normalizer.
`default_nettype none
package qtn_pkg;

  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] UC_A      = 8'h41;
  localparam logic [7:0] ALPHA_N   = 8'd26;
  localparam logic [7:0] CASE_BIT  = 8'h20;
  localparam logic [7:0] ASCII_TOP = 8'h80;

  localparam logic [7:0] LEAD_E2   = 8'hE2;
  localparam logic [7:0] MID_80    = 8'h80;
  localparam logic [7:0] LSQ       = 8'h98;
  localparam logic [7:0] RSQ       = 8'h99;
  localparam logic [7:0] LDQ       = 8'h9C;
  localparam logic [7:0] RDQ       = 8'h9D;
  localparam logic [7:0] DASH_LO   = 8'h92;
  localparam logic [7:0] DASH_HI   = 8'h95;

  localparam logic [1:0] ST_NONE   = 2'd0;
  localparam logic [1:0] ST_E2     = 2'd1;
  localparam logic [1:0] ST_E2_80  = 2'd2;

  // Up to four result words produced by one input byte.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [3:0]      vld;
    logic [2:0]      cnt;
    logic            last;
  } res_bundle_t;

endpackage
`default_nettype wire

### design/qtn_ifs.sv
// Valid/ready channel interfaces for raw text input and normalized output.
`default_nettype none
interface qtn_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface qtn_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface
`default_nettype wire

### design/qtn_norm.sv
// Normalization logic and stream state: maps one byte to a bundle of results.
`default_nettype none
module qtn_norm
  import qtn_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  cur_byte,
  input  wire logic        cur_last,
  output res_bundle_t      bundle
);

  typedef struct packed {
    res_bundle_t r;
    logic        aft;
    logic        sp;
    logic [1:0]  st;
  } acc_t;

  logic [1:0] prefix_stage;
  logic       after_space;
  logic       space_pending;
  acc_t       acc;

  function automatic acc_t push(acc_t a, logic [7:0] b, logic v);
    acc_t o;
    o = a;
    if (o.r.cnt < 3'd4) begin
      o.r.data[o.r.cnt[1:0]] = b;
      o.r.vld[o.r.cnt[1:0]]  = v;
      o.r.cnt                = o.r.cnt + 3'd1;
    end
    return o;
  endfunction

  // A held space is emitted just before the next printable byte.
  function automatic acc_t put_char(acc_t a, logic [7:0] b);
    acc_t o;
    o = a;
    if (o.sp) begin
      o = push(o, CH_SPACE, 1'b1);
    end
    o     = push(o, b, 1'b1);
    o.sp  = 1'b0;
    o.aft = 1'b0;
    return o;
  endfunction

  function automatic acc_t put_space(acc_t a);
    acc_t o;
    o = a;
    if (!o.aft) begin
      o.sp  = 1'b1;
      o.aft = 1'b1;
    end
    return o;
  endfunction

  function automatic acc_t handle_fresh(acc_t a, logic [7:0] b, logic last);
    acc_t       o;
    logic [7:0] off;
    o   = a;
    off = b - UC_A;
    if (b < ASCII_TOP) begin
      if (b == CH_HYPHEN || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR) begin
        o = put_space(o);
      end else if (off < ALPHA_N) begin
        o = put_char(o, b | CASE_BIT);
      end else begin
        o = put_char(o, b);
      end
    end else if (b == LEAD_E2 && !last) begin
      o.st = ST_E2;
    end else begin
      o = put_char(o, b);
    end
    return o;
  endfunction

  always_comb begin
    acc.r   = '0;
    acc.aft = after_space;
    acc.sp  = space_pending;
    acc.st  = ST_NONE;
    unique case (prefix_stage)
      ST_E2: begin
        if (cur_byte == MID_80 && !cur_last) begin
          acc.st = ST_E2_80;
        end else begin
          acc = put_char(acc, LEAD_E2);
          acc = handle_fresh(acc, cur_byte, cur_last);
        end
      end
      ST_E2_80: begin
        priority if (cur_byte == LSQ || cur_byte == RSQ) begin
          acc = put_char(acc, CH_APOS);
        end else if (cur_byte == LDQ || cur_byte == RDQ) begin
          acc = put_char(acc, CH_QUOTE);
        end else if (cur_byte >= DASH_LO && cur_byte <= DASH_HI) begin
          acc = put_space(acc);
        end else begin
          acc = put_char(acc, LEAD_E2);
          acc = put_char(acc, MID_80);
          acc = handle_fresh(acc, cur_byte, cur_last);
        end
      end
      default: begin
        acc = handle_fresh(acc, cur_byte, cur_last);
      end
    endcase
    // The final byte always yields at least one word, a bare end marker if nothing else.
    if (cur_last) begin
      if (acc.r.cnt == 3'd0) begin
        acc = push(acc, 8'h00, 1'b0);
      end
      acc.r.last = 1'b1;
    end
  end

  assign bundle = acc.r;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_stage  <= ST_NONE;
      after_space   <= 1'b1;
      space_pending <= 1'b0;
    end else if (step) begin
      if (cur_last) begin
        prefix_stage  <= ST_NONE;
        after_space   <= 1'b1;
        space_pending <= 1'b0;
      end else begin
        prefix_stage  <= acc.st;
        after_space   <= acc.aft;
        space_pending <= acc.sp;
      end
    end
  end

endmodule
`default_nettype wire

### design/qtn_serializer.sv
// Result register for one bundle; one word out per cycle while dst is ready.
`default_nettype none
module qtn_serializer
  import qtn_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire res_bundle_t bundle,
  output logic            free,
  qtn_out_if.source       dst
);

  res_bundle_t held;
  logic        full;
  logic [1:0]  idx;
  logic        at_end;
  logic        drain;
  logic        done;

  assign at_end = ({1'b0, idx} == (held.cnt - 3'd1));
  assign drain  = full && dst.ready;
  assign done   = drain && at_end;
  assign free   = !full || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= 2'd0;
    end else if (done) begin
      full <= 1'b0;
    end else if (drain) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

  assign dst.valid     = full;
  assign dst.out_byte  = held.data[idx];
  assign dst.out_valid = held.vld[idx];
  assign dst.out_last  = held.last && at_end;

endmodule
`default_nettype wire

### design/query_text_normalizer.sv
// Query text normalizer: lower-cases, folds quotes and dashes, collapses spaces.
// An accepted byte waits in the input register and is normalized combinationally; its
// result words are then loaded into the result register, from which they are offered.
// Throughput: one byte per cycle while bytes yield at most one word and out_ch is
// ready; a byte with two to four words holds the single result register until drained.
// Reset (rst, synchronous, active high) empties both registers and restarts the text
// state: no prefix held, leading spaces suppressed, no space pending.
`default_nettype none
module query_text_normalizer
  import qtn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  qtn_in_if.sink    in_ch,
  qtn_out_if.source out_ch
);

  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_last;
  res_bundle_t nb;
  logic        has_res;
  logic        free;
  logic        a_move;
  logic        load;

  // A byte with no result words only updates the state and never waits on the output.
  assign has_res      = (nb.cnt != 3'd0);
  assign a_move       = a_valid && (!has_res || free);
  assign load         = a_move && has_res;
  assign in_ch.ready  = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_byte <= in_ch.in_byte;
      a_last <= in_ch.in_last;
    end
  end

  qtn_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .step     (a_move),
    .cur_byte (a_byte),
    .cur_last (a_last),
    .bundle   (nb)
  );

  qtn_serializer u_ser (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .bundle (nb),
    .free   (free),
    .dst    (out_ch)
  );

`ifndef SYNTH
  // A bare end marker only ever closes a text.
  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.out_valid |-> out_ch.out_last)
    else $error("end marker without last flag");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.out_valid |-> out_ch.out_byte == 8'h00)
    else $error("end marker carries a nonzero byte");

  // A final byte always produces at least one word.
  a_last_has_res: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_last |-> has_res)
    else $error("final byte produced no result");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> out_ch.valid)
    else $error("loaded bundle not offered on output");
`endif

endmodule
`default_nettype wire
